@@ design/wfd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared types and constants for the frame deframer and its submodules.
// ----------------------------------------------------------------------------
package wfd_pkg;

    localparam int BYTE_W = 8;
    localparam int OPCODE_W = 4;
    localparam int LEN_W = 32;
    localparam int KEY_W = 32;
    localparam int OUT_TDATA_W = 16;
    localparam int FIFO_DEPTH_DEFAULT = 4;

    localparam logic [6:0] LEN16_CODE = 7'd126;

    typedef struct packed {
        logic [BYTE_W-1:0]   data;
        logic [BYTE_W-1:0]   key;
        logic [OPCODE_W-1:0] opcode;
        logic                fin;
        logic                last;
        logic                empty;
    } beat_t;

endpackage

@@ design/wfd_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket deframer header parser
// Accepts stream bytes, tracks the frame header and classifies payload bytes.
// ----------------------------------------------------------------------------
module wfd_parser
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        room,
    input  logic [wfd_pkg::BYTE_W-1:0]  in_data,
    output logic                        push,
    output wfd_pkg::beat_t              push_beat
);

    localparam logic [2:0] PH_HDR0 = 3'd0;
    localparam logic [2:0] PH_HDR1 = 3'd1;
    localparam logic [2:0] PH_EXT  = 3'd2;
    localparam logic [2:0] PH_KEY  = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;

    logic [2:0]                    phase_reg, phase_next;
    logic [wfd_pkg::OPCODE_W-1:0]  opcode_reg, opcode_next;
    logic                          fin_reg, fin_next;
    logic                          mask_reg, mask_next;
    logic [2:0]                    hcount_reg, hcount_next;
    logic [wfd_pkg::LEN_W-1:0]     len_reg, len_next;
    logic [wfd_pkg::KEY_W-1:0]     key_reg, key_next;
    logic [1:0]                    pos_reg, pos_next;

    logic                          accept;
    logic                          len_done;
    logic                          hdr_done;
    logic [wfd_pkg::BYTE_W-1:0]    key_byte;

    assign accept = in_valid && room;

    always_comb
    begin
        case (pos_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        opcode_next = opcode_reg;
        fin_next    = fin_reg;
        mask_next   = mask_reg;
        hcount_next = hcount_reg;
        len_next    = len_reg;
        key_next    = key_reg;
        pos_next    = pos_reg;
        len_done    = 1'b0;
        hdr_done    = 1'b0;
        push        = 1'b0;
        push_beat   = '0;

        case (phase_reg)
            PH_HDR1:
            begin
                mask_next = in_data[7];
                if (in_data[6:0] < wfd_pkg::LEN16_CODE)
                begin
                    len_next = {{(wfd_pkg::LEN_W-7){1'b0}}, in_data[6:0]};
                    len_done = 1'b1;
                end
                else
                begin
                    len_next    = '0;
                    hcount_next = (in_data[6:0] == wfd_pkg::LEN16_CODE) ? 3'd1 : 3'd7;
                    phase_next  = PH_EXT;
                end
            end
            PH_EXT:
            begin
                len_next = {len_reg[wfd_pkg::LEN_W-9:0], in_data};
                if (hcount_reg == 3'd0)
                begin
                    len_done = 1'b1;
                end
                else
                begin
                    hcount_next = hcount_reg - 3'd1;
                end
            end
            PH_KEY:
            begin
                key_next = {key_reg[wfd_pkg::KEY_W-9:0], in_data};
                if (hcount_reg == 3'd0)
                begin
                    hdr_done = 1'b1;
                end
                else
                begin
                    hcount_next = hcount_reg - 3'd1;
                end
            end
            PH_DATA:
            begin
                pos_next         = pos_reg + 2'd1;
                len_next         = len_reg - 1'b1;
                push             = accept;
                push_beat.data   = in_data;
                push_beat.key    = mask_reg ? key_byte : '0;
                push_beat.opcode = opcode_reg;
                push_beat.fin    = fin_reg;
                push_beat.last   = (len_reg == {{(wfd_pkg::LEN_W-1){1'b0}}, 1'b1});
                push_beat.empty  = 1'b0;
                if (push_beat.last)
                begin
                    phase_next = PH_HDR0;
                end
            end
            default:
            begin
                fin_next    = in_data[7];
                opcode_next = in_data[3:0];
                mask_next   = 1'b0;
                hcount_next = 3'd0;
                len_next    = '0;
                key_next    = '0;
                pos_next    = 2'd0;
                phase_next  = PH_HDR1;
            end
        endcase

        if (len_done)
        begin
            if (mask_next)
            begin
                hcount_next = 3'd3;
                key_next    = '0;
                phase_next  = PH_KEY;
            end
            else
            begin
                hdr_done = 1'b1;
            end
        end

        if (hdr_done)
        begin
            if (len_next == '0)
            begin
                push             = accept;
                push_beat.data   = '0;
                push_beat.key    = '0;
                push_beat.opcode = opcode_reg;
                push_beat.fin    = fin_reg;
                push_beat.last   = 1'b1;
                push_beat.empty  = 1'b1;
                phase_next       = PH_HDR0;
            end
            else
            begin
                pos_next   = 2'd0;
                phase_next = PH_DATA;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            opcode_reg <= '0;
            fin_reg    <= 1'b0;
            mask_reg   <= 1'b0;
            hcount_reg <= '0;
            len_reg    <= '0;
            key_reg    <= '0;
            pos_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            fin_reg    <= fin_next;
            mask_reg   <= mask_next;
            hcount_reg <= hcount_next;
            len_reg    <= len_next;
            key_reg    <= key_next;
            pos_reg    <= pos_next;
        end
    end

endmodule

@@ design/wfd_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket deframer beat queue
// Short queue between the header parser and the output stage.
// ----------------------------------------------------------------------------
module wfd_fifo
#(
    parameter int DEPTH = wfd_pkg::FIFO_DEPTH_DEFAULT
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  wfd_pkg::beat_t push_beat,
    input  logic           pop,
    output wfd_pkg::beat_t pop_beat,
    output logic           full,
    output logic           not_empty
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    wfd_pkg::beat_t    mem [DEPTH];
    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_beat  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_ADDR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_ADDR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_beat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ design/wfd_out.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket deframer output stage
// Unmasks queued payload beats and holds them in the output register.
// ----------------------------------------------------------------------------
module wfd_out
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             avail,
    input  wfd_pkg::beat_t                   beat,
    output logic                             pop,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [wfd_pkg::OUT_TDATA_W-1:0]  out_data,
    output logic                             out_last,
    output logic                             out_user
);

    logic                            valid_reg, valid_next;
    logic [wfd_pkg::BYTE_W-1:0]      byte_reg;
    logic [wfd_pkg::OPCODE_W-1:0]    opcode_reg;
    logic                            fin_reg;
    logic                            last_reg;
    logic                            empty_reg;

    assign pop = avail && (!valid_reg || out_ready);

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            byte_reg   <= beat.data ^ beat.key;
            opcode_reg <= beat.opcode;
            fin_reg    <= beat.fin;
            last_reg   <= beat.last;
            empty_reg  <= beat.empty;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = {{(wfd_pkg::OUT_TDATA_W - wfd_pkg::BYTE_W - wfd_pkg::OPCODE_W - 1){1'b0}},
                        fin_reg, opcode_reg, byte_reg};
    assign out_last  = last_reg;
    assign out_user  = empty_reg;

endmodule

@@ design/websocket_frame_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses received WebSocket frames byte by byte and delivers unmasked payload.
// ----------------------------------------------------------------------------
// Channel  Dir  Signals                      Contents
// s        in   s_tvalid s_tready s_tdata    one received stream byte per beat
// m        out  m_tvalid m_tready m_tdata    payload byte, opcode, FIN bit
//               m_tlast m_tuser              last byte of frame, empty frame
//
// One byte is accepted every cycle while the beat queue has room; its result
// is written into the queue at that edge, then to the output register when free.
// Header bytes produce no beat except the one closing a zero-length frame.
// Reset clears the parser, queue pointers and output valid at once.
// A stalled output fills the queue; input stalls once the queue is full.
// ----------------------------------------------------------------------------
module websocket_frame_deframer
#(
    parameter int FIFO_DEPTH = wfd_pkg::FIFO_DEPTH_DEFAULT
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [wfd_pkg::BYTE_W-1:0]       s_tdata,   // [7:0] data_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [wfd_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [7:0] payload_byte,
                                                        // [11:8] opcode,
                                                        // [12] final_fragment
    output logic                             m_tlast,
    output logic                             m_tuser    // [0] empty_res
);

    logic           push;
    wfd_pkg::beat_t push_beat;
    logic           pop;
    wfd_pkg::beat_t pop_beat;
    logic           full;
    logic           not_empty;

    assign s_tready = !full;

    wfd_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .room      (!full),
        .in_data   (s_tdata),
        .push      (push),
        .push_beat (push_beat)
    );

    wfd_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_beat (push_beat),
        .pop       (pop),
        .pop_beat  (pop_beat),
        .full      (full),
        .not_empty (not_empty)
    );

    wfd_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .avail     (not_empty),
        .beat      (pop_beat),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast),
        .out_user  (m_tuser)
    );

endmodule

@@ design/wfd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket deframer port checker
// Concurrent assertions on the deframer's output port behavior.
// ----------------------------------------------------------------------------
module wfd_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [wfd_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input logic                             m_tlast,
    input logic                             m_tuser
);

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("Empty-frame beat without last.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata[7:0] == 8'd0))
        else $error("Empty-frame beat carries a payload byte.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("Output valid dropped while stalled.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
        else $error("Output beat changed while stalled.");

endmodule

bind websocket_frame_deframer wfd_checker u_wfd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Feeds a byte stream of complete frames into the deframer and checks every
// payload beat against an internal header parser. The stream mixes plain,
// masked, empty and extended-length frames. Sender and receiver idle at
// random, the receiver holds off long enough to fill the beat queue, and the
// sender drains between phases.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 150;
    localparam int MAX_REPORTS = 10;

    localparam logic [6:0] LEN64_CODE = 7'd127;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    typedef enum logic [2:0]
    {
        AWAIT_HEAD = 3'd0,
        AWAIT_LEN  = 3'd1,
        EXT_LEN    = 3'd2,
        MASK_KEY   = 3'd3,
        PAYLOAD    = 3'd4
    } parse_phase_e;

    typedef enum int
    {
        FORM_SHORT,
        FORM_EXT16,
        FORM_EXT64
    } len_form_e;

    typedef struct packed {
        logic [wfd_pkg::BYTE_W-1:0]   payload;
        logic [wfd_pkg::OPCODE_W-1:0] opcode;
        logic                         fin;
        logic                         last;
        logic                         empty;
    } payload_beat_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [wfd_pkg::BYTE_W-1:0]      s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [wfd_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            m_tlast;
    logic                            m_tuser;

    logic [wfd_pkg::BYTE_W-1:0] rx_stream [$];
    payload_beat_t              payload_due [$];

    parse_phase_e                 hdr_phase = AWAIT_HEAD;
    logic [wfd_pkg::OPCODE_W-1:0] hdr_opcode = '0;
    logic                         hdr_fin = 1'b0;
    logic                         hdr_masked = 1'b0;
    logic [2:0]                   hdr_left = '0;
    logic [wfd_pkg::LEN_W-1:0]    bytes_left = '0;
    logic [wfd_pkg::KEY_W-1:0]    mask_word = '0;
    logic [1:0]                   key_index = '0;

    logic tx_idling = 1'b1;
    logic rx_idling = 1'b1;
    int   hold_req = 0;
    int   hold_seen = 0;
    int   hold_left = 0;
    int   gap_left = 0;
    int   stall_left = 0;

    int fault_count = 0;
    int cycle_count = 0;
    int bytes_queued = 0;
    int frames_queued = 0;
    int masked_frames = 0;
    int ext16_frames = 0;
    int ext64_frames = 0;
    int beats_checked = 0;
    int empty_seen = 0;

    logic [7:0] opening_bytes [0:29] = '{
        8'h89, 8'h00,
        8'h0F, 8'h80, 8'h00, 8'hFF, 8'h00, 8'hFF,
        8'h81, 8'h81, 8'hAA, 8'h55, 8'hFF, 8'h00, 8'hFF,
        8'h02, 8'h7E, 8'h00, 8'h00,
        8'h80, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00
    };

    websocket_frame_deframer u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic close_header();
        if (bytes_left == '0)
        begin
            payload_due.push_back('{payload: '0, opcode: hdr_opcode, fin: hdr_fin,
                                    last: 1'b1, empty: 1'b1});
            hdr_phase = AWAIT_HEAD;
        end
        else
        begin
            key_index = '0;
            hdr_phase = PAYLOAD;
        end
    endtask

    task automatic length_known();
        if (hdr_masked)
        begin
            hdr_left = 3'd3;
            mask_word = '0;
            hdr_phase = MASK_KEY;
        end
        else
        begin
            close_header();
        end
    endtask

    task automatic parse_stream_byte(input logic [wfd_pkg::BYTE_W-1:0] b);
        logic [6:0]                 len7;
        logic [wfd_pkg::BYTE_W-1:0] key_byte;
        case (hdr_phase)
            AWAIT_LEN:
            begin
                hdr_masked = b[7];
                len7 = b[6:0];
                bytes_left = '0;
                if (len7 < wfd_pkg::LEN16_CODE)
                begin
                    bytes_left = {{(wfd_pkg::LEN_W-7){1'b0}}, len7};
                    length_known();
                end
                else
                begin
                    hdr_left = (len7 == wfd_pkg::LEN16_CODE) ? 3'd1 : 3'd7;
                    hdr_phase = EXT_LEN;
                end
            end
            EXT_LEN:
            begin
                bytes_left = {bytes_left[wfd_pkg::LEN_W-9:0], b};
                if (hdr_left == '0)
                    length_known();
                else
                    hdr_left = hdr_left - 3'd1;
            end
            MASK_KEY:
            begin
                mask_word = {mask_word[wfd_pkg::KEY_W-9:0], b};
                if (hdr_left == '0)
                    close_header();
                else
                    hdr_left = hdr_left - 3'd1;
            end
            PAYLOAD:
            begin
                key_byte = hdr_masked ? mask_word[31 - 8 * key_index -: 8] : '0;
                key_index = key_index + 2'd1;
                bytes_left = bytes_left - 1;
                payload_due.push_back('{payload: b ^ key_byte, opcode: hdr_opcode,
                                        fin: hdr_fin, last: bytes_left == '0,
                                        empty: 1'b0});
                if (bytes_left == '0)
                    hdr_phase = AWAIT_HEAD;
            end
            default:
            begin
                hdr_fin = b[7];
                hdr_opcode = b[3:0];
                hdr_masked = 1'b0;
                hdr_left = '0;
                bytes_left = '0;
                mask_word = '0;
                key_index = '0;
                hdr_phase = AWAIT_LEN;
            end
        endcase
    endtask

    task automatic push_stream_byte(input logic [7:0] b);
        rx_stream.push_back(b);
        bytes_queued++;
    endtask

    task automatic queue_frame(input logic fin, input logic [2:0] rsv,
                               input logic [3:0] opcode, input logic masked,
                               input len_form_e form, input int unsigned len);
        logic [31:0] key;
        key = $urandom;
        push_stream_byte({fin, rsv, opcode});
        case (form)
            FORM_EXT16:
            begin
                push_stream_byte({masked, wfd_pkg::LEN16_CODE});
                push_stream_byte(len[15:8]);
                push_stream_byte(len[7:0]);
                ext16_frames++;
            end
            FORM_EXT64:
            begin
                push_stream_byte({masked, LEN64_CODE});
                for (int i = 0; i < 4; i++)
                    push_stream_byte(8'($urandom));
                for (int i = 3; i >= 0; i--)
                    push_stream_byte(len[8 * i +: 8]);
                ext64_frames++;
            end
            default:
            begin
                push_stream_byte({masked, len[6:0]});
            end
        endcase
        if (masked)
        begin
            for (int i = 3; i >= 0; i--)
                push_stream_byte(key[8 * i +: 8]);
            masked_frames++;
        end
        for (int unsigned i = 0; i < len; i++)
            push_stream_byte(8'($urandom));
        frames_queued++;
    endtask

    task automatic queue_random_frame();
        logic [3:0]  opcode;
        logic [2:0]  rsv;
        int unsigned len;
        len_form_e   form;
        int          pick;
        rsv = '0;
        if ($urandom_range(0, 99) < 85)
        begin
            case ($urandom_range(0, 5))
                0: opcode = OP_CONT;
                1: opcode = OP_TEXT;
                2: opcode = OP_BINARY;
                3: opcode = OP_CLOSE;
                4: opcode = OP_PING;
                default: opcode = OP_PONG;
            endcase
        end
        else
        begin
            opcode = 4'($urandom);
            rsv = 3'($urandom);
        end
        pick = $urandom_range(0, 99);
        if (pick < 8)
            len = 0;
        else if (pick < 80)
            len = $urandom_range(1, 12);
        else if (pick < 94)
            len = $urandom_range(13, 125);
        else
            len = $urandom_range(126, 300);
        pick = $urandom_range(0, 99);
        if (len > 125)
            form = (pick < 25) ? FORM_EXT64 : FORM_EXT16;
        else if (pick < 80)
            form = FORM_SHORT;
        else if (pick < 92)
            form = FORM_EXT16;
        else
            form = FORM_EXT64;
        queue_frame(1'($urandom), rsv, opcode, $urandom_range(0, 4) != 0, form, len);
    endtask

    task automatic wait_for_drain();
        do
            @(negedge clk);
        while (rx_stream.size() != 0 || s_tvalid || payload_due.size() != 0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            gap_left = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                parse_stream_byte(s_tdata);
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (rx_stream.size() != 0)
                begin
                    s_tdata <= rx_stream.pop_front();
                    s_tvalid <= 1'b1;
                    gap_left = tx_idling ? $urandom_range(0, 19) : 0;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        payload_beat_t got;
        payload_beat_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = '{payload: m_tdata[7:0], opcode: m_tdata[11:8], fin: m_tdata[12],
                        last: m_tlast, empty: m_tuser};
                beats_checked++;
                if (got.empty)
                    empty_seen++;
                if (payload_due.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                        $display("%0t: unexpected beat data %h op %h fin %b last %b empty %b",
                                 $realtime, got.payload, got.opcode, got.fin, got.last,
                                 got.empty);
                end
                else
                begin
                    want = payload_due.pop_front();
                    if (got != want)
                    begin
                        fault_count++;
                        if (fault_count <= MAX_REPORTS)
                        begin
                            $display("%0t: beat mismatch, expected data %h op %h fin %b %s",
                                     $realtime, want.payload, want.opcode, want.fin,
                                     $sformatf("last %b empty %b", want.last, want.empty));
                            $display("%0t: beat mismatch, got data %h op %h fin %b %s",
                                     $realtime, got.payload, got.opcode, got.fin,
                                     $sformatf("last %b empty %b", got.last, got.empty));
                        end
                    end
                end
                stall_left = rx_idling ? $urandom_range(0, 19) : 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (hold_seen != hold_req)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (opening_bytes[i])
            push_stream_byte(opening_bytes[i]);
        frames_queued += 5;
        wait_for_drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            tx_idling = phase[0];
            rx_idling = phase[1];
            if (phase == 4)
                hold_req++;
            while (bytes_queued < 30 + 190 * (phase + 1))
                queue_random_frame();
            wait_for_drain();
        end

        repeat (10) @(negedge clk);
        $display("Checked %0d beats (%0d empty frames) from %0d frames in %0d stream bytes.",
                 beats_checked, empty_seen, frames_queued, bytes_queued);
        $display("Masked frames %0d, 16-bit lengths %0d, 64-bit lengths %0d, hold-offs %0d.",
                 masked_frames, ext16_frames, ext64_frames, hold_req);
        if (fault_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
